// ===== hdl/bfa_pkg.sv =====
// bfa_pkg: shared types and constants for the bitmap frame allocator
// used by the allocator top level, its map memory and its checker; no dependencies

package bfa_pkg;

  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int FRAME_W    = 16;
  localparam int COUNT_W    = 17;
  localparam int WNUM_W     = COUNT_W - BIT_W;
  localparam int FRAME_BYTES = 4096;
  localparam int MAX_FRAMES = 65536;

  localparam logic [COUNT_W-1:0] FRAMES_RESET = 17'h10000;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_RESERVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PICK,
    S_RUN,
    S_DONE
  } state_t;

endpackage

// ===== hdl/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: first-fit frame allocator over a one-bit-per-frame map
// depends on bfa_pkg and bfa_map_ram

// The map lives in a word memory of MAX_FRAMES/64 words of 64 bits. After reset
// a clearing pass marks every frame used, one word a cycle, and in_ready stays
// low until it ends. One request is handled at a time. An alloc reads the map
// one word a cycle from word 0 until it meets a free frame below the frame
// count. A free or a range request reads and writes back each word that the
// range spans through the one shared masking unit. A finished result waits in
// the output register while the next request is taken. Granted frame
// addresses are the index times 4096.

module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [FRAME_W-1:0] frame_index,
  input  logic [COUNT_W-1:0] range_len,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [FRAME_W-1:0] granted_frame
);

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  state_t               state, state_next;
  logic [AW-1:0]        clr_addr, clr_addr_next;
  logic [COUNT_W-1:0]   frames_in_use;
  req_t                 kind;
  logic [FRAME_W-1:0]   first_f;
  logic [COUNT_W-1:0]   count_f;
  logic [WNUM_W-1:0]    last_w, last_w_next;
  logic [BIT_W-1:0]     last_bit, last_bit_next;
  logic [WNUM_W-1:0]    scan_w, scan_w_next;
  logic                 pend, pend_next;
  logic [WNUM_W-1:0]    pend_w, pend_w_next;
  logic [WORD_BITS-1:0] hit_data, hit_data_next;
  logic [WORD_BITS-1:0] hit_avail, hit_avail_next;
  logic [WNUM_W-1:0]    hit_w, hit_w_next;
  status_t              res_status, res_status_next;
  logic [FRAME_W-1:0]   res_frame, res_frame_next;
  logic                 out_valid_next;
  logic                 load_out;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [COUNT_W-1:0]   limit;
  logic [COUNT_W-1:0]   room;
  logic [COUNT_W-1:0]   last_f;
  logic [WNUM_W-1:0]    first_w;
  logic [WORD_BITS-1:0] alloc_mask, range_mask, avail;
  logic [BIT_W-1:0]     lo_bit, hi_bit;
  logic [WORD_BITS-1:0] onehot;
  logic [BIT_W-1:0]     pick_bit;
  logic                 issue;

  bfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_valid) begin
      frames_in_use <= cfg_data;
    end
  end

  // effective frame count, saturated to the map size
  always_comb begin
    if (32'(frames_in_use) > MAX_FRAMES) begin
      limit = COUNT_W'(MAX_FRAMES);
    end else begin
      limit = frames_in_use;
    end
    room    = limit - COUNT_W'(first_f);
    last_f  = COUNT_W'(first_f) + count_f - COUNT_W'(1);
    first_w = WNUM_W'(first_f[FRAME_W-1:BIT_W]);
  end

  // shared word unit: lane masks, free-bit search and lowest-bit pick
  always_comb begin
    lo_bit = (pend_w == first_w) ? first_f[BIT_W-1:0] : '0;
    hi_bit = (pend_w == last_w) ? last_bit : '1;
    for (int i = 0; i < WORD_BITS; i++) begin
      alloc_mask[i] = (pend_w != limit[COUNT_W-1:BIT_W]) ||
                      (BIT_W'(i) < limit[BIT_W-1:0]);
      range_mask[i] = (BIT_W'(i) >= lo_bit) && (BIT_W'(i) <= hi_bit);
    end
    avail    = ~ram_rdata & alloc_mask;
    onehot   = hit_avail & (~hit_avail + WORD_BITS'(1));
    pick_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pick_bit = pick_bit | (onehot[i] ? BIT_W'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind    <= req_t'(req_type);
      first_f <= frame_index;
      count_f <= (req_t'(req_type) == REQ_FREE) ? COUNT_W'(1) : range_len;
    end
    last_w     <= last_w_next;
    last_bit   <= last_bit_next;
    scan_w     <= scan_w_next;
    pend_w     <= pend_w_next;
    hit_data   <= hit_data_next;
    hit_avail  <= hit_avail_next;
    hit_w      <= hit_w_next;
    res_status <= res_status_next;
    res_frame  <= res_frame_next;
    if (load_out) begin
      status        <= res_status;
      granted_frame <= res_frame;
    end
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    last_w_next     = last_w;
    last_bit_next   = last_bit;
    scan_w_next     = scan_w;
    pend_next       = 1'b0;
    pend_w_next     = pend_w;
    hit_data_next   = hit_data;
    hit_avail_next  = hit_avail;
    hit_w_next      = hit_w;
    res_status_next = res_status;
    res_frame_next  = res_frame;
    out_valid_next  = out_valid && !out_ready;
    ram_we          = 1'b0;
    ram_waddr       = AW'(pend_w);
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = AW'(scan_w);
    issue           = 1'b0;

    unique case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '1;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(MAP_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        scan_w_next     = '0;
        res_status_next = ST_DONE;
        res_frame_next  = '0;
        if (in_valid) begin
          state_next = (req_t'(req_type) == REQ_ALLOC) ? S_SCAN : S_CHECK;
        end
      end
      S_CHECK: begin
        last_w_next   = last_f[COUNT_W-1:BIT_W];
        last_bit_next = last_f[BIT_W-1:0];
        scan_w_next   = first_w;
        if ((COUNT_W'(first_f) >= limit) || (count_f > room)) begin
          res_status_next = ST_RANGE;
          state_next      = S_DONE;
        end else if (count_f == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RUN;
        end
      end
      S_SCAN: begin
        // reads run one word ahead of the evaluation of the previous word
        if (pend && (avail != '0)) begin
          hit_data_next  = ram_rdata;
          hit_avail_next = avail;
          hit_w_next     = pend_w;
          state_next     = S_PICK;
        end else begin
          issue = {scan_w, {BIT_W{1'b0}}} < limit;
          if (issue) begin
            ram_re      = 1'b1;
            scan_w_next = scan_w + WNUM_W'(1);
            pend_next   = 1'b1;
            pend_w_next = scan_w;
          end else begin
            res_status_next = ST_OOM;
            state_next      = S_DONE;
          end
        end
      end
      S_PICK: begin
        ram_we         = 1'b1;
        ram_waddr      = AW'(hit_w);
        ram_wdata      = hit_data | onehot;
        res_frame_next = FRAME_W'({hit_w, pick_bit});
        state_next     = S_DONE;
      end
      S_RUN: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_wdata = (kind == REQ_RESERVE) ? (ram_rdata | range_mask)
                                            : (ram_rdata & ~range_mask);
        end
        issue = (scan_w <= last_w);
        if (issue) begin
          ram_re      = 1'b1;
          scan_w_next = scan_w + WNUM_W'(1);
          pend_next   = 1'b1;
          pend_w_next = scan_w;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bfa_map_ram.sv =====
// bfa_map_ram: one-write one-read word memory holding the frame bitmap
// registered read data; depends on bfa_pkg for the word width

module bfa_map_ram import bfa_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bfa_checker.sv =====
// bfa_checker: port-level assertions for bitmap_frame_allocator, bound to the top
// depends on bfa_pkg for the status codes

module bfa_checker import bfa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [FRAME_W-1:0] granted_frame
);

  // one request in flight: a transfer in closes the input side next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request accepted during map clearing");

  // only a successful alloc carries a frame
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DONE)) |-> (granted_frame == '0))
    else $error("frame reported with a failure status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DONE || status == ST_OOM || status == ST_RANGE))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(granted_frame)))
    else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .granted_frame (granted_frame)
);
